// ===== rtl/pcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsr_pkg
// shared types, register map and crc helper for the paged crc32c stream reader
// ----------------------------------------------------------------------------
package pcsr_pkg;

  // apb register map
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam logic [1:0] REG_PAGE_SHIFT   = 2'd0;
  localparam logic [1:0] REG_START_OFFSET = 2'd1;
  localparam logic [1:0] REG_READ_LENGTH  = 2'd2;

  localparam logic [4:0]  PAGE_SHIFT_RST = 5'd10;
  localparam logic [4:0]  MIN_SHIFT      = 5'd3;
  localparam logic [31:0] CRC_POLY       = 32'h82f6_3b78;
  localparam logic [31:0] CRC_ONES       = 32'hffff_ffff;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_PAGE_OK = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_OFS_ERR = 2'd3
  } kind_e;

  // classification made at the front
  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_START    = 2'd1,
    CMD_ZERO_LEN = 2'd2,
    CMD_OFS_ERR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [7:0] page_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic [47:0] next_offset;
    logic [31:0] page_crc;
  } out_item_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  page_byte;
    logic [4:0]  shift;
    logic [31:0] length;
  } cmd_t;

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc32c_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/pcsr_front.sv =====
// ----------------------------------------------------------------------------
// pcsr_front
// classifies each incoming byte against the current register settings
// ----------------------------------------------------------------------------
module pcsr_front #(
  parameter int MAX_PAGE_SHIFT = 16,
  parameter int OFFSET_WIDTH   = 48
) (
  input  pcsr_pkg::in_item_t        in_item_i,
  input  logic [4:0]                page_shift_i,
  input  logic [47:0]               start_offset_i,
  input  logic [31:0]               read_length_i,
  output pcsr_pkg::cmd_t            cmd_o,
  output logic [MAX_PAGE_SHIFT-1:0] in_page_o,
  output logic [OFFSET_WIDTH-1:0]   offset_o
);
  import pcsr_pkg::*;

  localparam int PW = MAX_PAGE_SHIFT + 1;
  localparam logic [4:0] MaxShift = 5'(MAX_PAGE_SHIFT);

  logic [4:0]    shift;
  logic [PW-1:0] size;
  logic [PW-1:0] payload;
  logic [PW-1:0] mask;

  always_comb begin
    // clamp page size into the supported range
    if (page_shift_i < MIN_SHIFT) begin
      shift = MIN_SHIFT;
    end else if (page_shift_i > MaxShift) begin
      shift = MaxShift;
    end else begin
      shift = page_shift_i;
    end
    size    = PW'(1) << shift;
    payload = size - PW'(4);
    mask    = size - PW'(1);
  end

  assign in_page_o = start_offset_i[MAX_PAGE_SHIFT-1:0] & mask[MAX_PAGE_SHIFT-1:0];
  assign offset_o  = OFFSET_WIDTH'(start_offset_i);

  always_comb begin
    cmd_o.page_byte = in_item_i.page_byte;
    cmd_o.shift     = shift;
    cmd_o.length    = read_length_i;
    priority if (!in_item_i.start_req) begin
      cmd_o.cmd = CMD_BYTE;
    end else if ({1'b0, in_page_o} >= payload) begin
      cmd_o.cmd = CMD_OFS_ERR;
    end else if (read_length_i == 32'd0) begin
      cmd_o.cmd = CMD_ZERO_LEN;
    end else begin
      cmd_o.cmd = CMD_START;
    end
  end

endmodule

// ===== rtl/pcsr_queue.sv =====
// ----------------------------------------------------------------------------
// pcsr_queue
// small register fifo between the front and the back
// ----------------------------------------------------------------------------
module pcsr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/pcsr_back.sv =====
// ----------------------------------------------------------------------------
// pcsr_back
// page walker: crc update, position tracking, result generation, output register
// ----------------------------------------------------------------------------
module pcsr_back #(
  parameter int MAX_PAGE_SHIFT = 16,
  parameter int OFFSET_WIDTH   = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  pcsr_pkg::cmd_t            cmd_i,
  input  logic [MAX_PAGE_SHIFT-1:0] in_page_i,
  input  logic [OFFSET_WIDTH-1:0]   offset_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pcsr_pkg::out_item_t       out_item_o
);
  import pcsr_pkg::*;

  localparam int PW = MAX_PAGE_SHIFT + 1;
  localparam int MW = MAX_PAGE_SHIFT;
  localparam int OW = OFFSET_WIDTH;

  logic [31:0]   crc_q, crc_d, crc_e, crc_upd;
  logic [MW-1:0] pos_q, pos_d, pos_e;
  logic [31:0]   sc_q, sc_d, sc_e;
  logic [31:0]   bl_q, bl_d, bl_e;
  logic [OW-1:0] pidx_q, pidx_d, pidx_e;
  logic [OW-1:0] resume_q, resume_d, resume_e;
  logic          active_q, active_d, act_e;
  logic          first_q, first_d, first_e;
  logic          fin_q, fin_d, fin_e;

  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d, res;
  logic          emit, is_start;

  logic [PW-1:0] size, payload, last_pos, pos_ext;
  logic [31:0]   crc_fin;
  logic [OW-1:0] end_off;

  assign pop_o       = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    size     = PW'(1) << cmd_i.shift;
    payload  = size - PW'(4);
    last_pos = size - PW'(1);
    is_start = (cmd_i.cmd == CMD_START);

    // a start rearms all state before the byte itself is walked
    act_e    = is_start || active_q;
    crc_e    = is_start ? CRC_ONES : crc_q;
    pos_e    = is_start ? '0 : pos_q;
    sc_e     = is_start ? '0 : sc_q;
    bl_e     = is_start ? cmd_i.length : bl_q;
    pidx_e   = is_start ? (offset_i >> cmd_i.shift) : pidx_q;
    resume_e = is_start ? '0 : resume_q;
    first_e  = is_start || first_q;
    fin_e    = !is_start && fin_q;

    pos_ext  = {1'b0, pos_e};
    crc_upd  = crc32c_byte(crc_e, cmd_i.page_byte);
    crc_fin  = crc_e ^ CRC_ONES;
    // offset just past this byte, past the checksum at payload end
    end_off  = (pidx_e << cmd_i.shift) + OW'(pos_ext) +
               (((pos_ext + PW'(1)) == payload) ? OW'(5) : OW'(1));

    crc_d    = crc_e;
    pos_d    = pos_e;
    sc_d     = sc_e;
    bl_d     = bl_e;
    pidx_d   = pidx_e;
    resume_d = resume_e;
    active_d = act_e;
    first_d  = first_e;
    fin_d    = fin_e;

    emit             = 1'b0;
    res.kind         = KIND_DATA;
    res.data         = '0;
    res.last         = 1'b0;
    res.next_offset  = '0;
    res.page_crc     = '0;

    unique case (cmd_i.cmd)
      CMD_OFS_ERR: begin
        active_d = 1'b0;
        emit     = 1'b1;
        res.kind = KIND_OFS_ERR;
        res.last = 1'b1;
      end
      CMD_ZERO_LEN: begin
        active_d        = 1'b0;
        emit            = 1'b1;
        res.kind        = KIND_PAGE_OK;
        res.last        = 1'b1;
        res.next_offset = 48'(offset_i);
      end
      CMD_BYTE, CMD_START: begin
        if (act_e) begin
          if (pos_ext < payload) begin
            // payload byte
            crc_d = crc_upd;
            pos_d = pos_e + MW'(1);
            if ((bl_e != 32'd0) && (!first_e || (pos_e >= in_page_i))) begin
              bl_d = bl_e - 32'd1;
              if (bl_e == 32'd1) begin
                resume_d = end_off;
                fin_d    = 1'b1;
              end
              emit     = 1'b1;
              res.data = cmd_i.page_byte;
            end
          end else begin
            // checksum byte, big-endian
            sc_d = {sc_e[23:0], cmd_i.page_byte};
            if (pos_ext < last_pos) begin
              pos_d = pos_e + MW'(1);
            end else begin
              emit         = 1'b1;
              res.page_crc = crc_fin;
              if (crc_fin != sc_d) begin
                active_d = 1'b0;
                res.kind = KIND_CRC_ERR;
                res.last = 1'b1;
              end else if (fin_e) begin
                active_d        = 1'b0;
                res.kind        = KIND_PAGE_OK;
                res.last        = 1'b1;
                res.next_offset = 48'(resume_e);
              end else begin
                res.kind = KIND_PAGE_OK;
                pidx_d   = pidx_e + OW'(1);
                pos_d    = '0;
                crc_d    = CRC_ONES;
                sc_d     = '0;
                first_d  = 1'b0;
              end
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_ONES;
      pos_q       <= '0;
      sc_q        <= '0;
      bl_q        <= '0;
      pidx_q      <= '0;
      resume_q    <= '0;
      active_q    <= 1'b0;
      first_q     <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        crc_q    <= crc_d;
        pos_q    <= pos_d;
        sc_q     <= sc_d;
        bl_q     <= bl_d;
        pidx_q   <= pidx_d;
        resume_q <= resume_d;
        active_q <= active_d;
        first_q  <= first_d;
        fin_q    <= fin_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== rtl/paged_crc32c_stream_reader_unit.sv =====
// ----------------------------------------------------------------------------
// paged_crc32c_stream_reader_unit
// reads whole pages byte by byte, checks their crc-32c and delivers payload
// ----------------------------------------------------------------------------
// usage
//   - program page_shift, start_offset and read_length over the apb port
//     while no transfer is in flight (byte addresses 0x0, 0x8, 0x10)
//   - feed raw page bytes on in_valid_i/in_ready_o, one byte per transfer,
//     starting at byte 0 of the page holding start_offset with start_req set
//   - results leave on out_valid_o/out_ready_i: payload bytes, one status item
//     at each page end, and a final item with last set (done or error)
// timing
//   - one input transfer per cycle sustained while out_ready_i stays high; a
//     result passes the fifo write, then the page walker and output register
//   - the rate is set by the crc byte update in the page walker, one byte
//     per cycle
// stall behavior
//   - a two-entry fifo separates intake from the page walker; when the
//     receiver stalls the output register holds, the fifo fills and then
//     in_ready_o drops
// reset
//   - registers return to page_shift 10, start_offset 0, read_length 0;
//     the walker is idle and ignores bytes until the next start
// ----------------------------------------------------------------------------
module paged_crc32c_stream_reader_unit #(
  parameter int MAX_PAGE_SHIFT = 16,
  parameter int OFFSET_WIDTH   = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // byte input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  pcsr_pkg::in_item_t                   in_item_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pcsr_pkg::out_item_t                  out_item_o,
  // apb register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pcsr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pcsr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pcsr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import pcsr_pkg::*;

  localparam int MW = MAX_PAGE_SHIFT;
  localparam int OW = OFFSET_WIDTH;
  localparam int QW = $bits(cmd_t) + MW + OW;

  // configuration registers
  logic [4:0]  page_shift_q;
  logic [47:0] start_offset_q;
  logic [31:0] read_length_q;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  // front to queue
  cmd_t          f_cmd;
  logic [MW-1:0] f_in_page;
  logic [OW-1:0] f_offset;
  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_rdata;

  // queue head as seen by the walker
  cmd_t          h_cmd;
  logic [MW-1:0] h_in_page;
  logic [OW-1:0] h_offset;

  // register access, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q   <= PAGE_SHIFT_RST;
      start_offset_q <= '0;
      read_length_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAGE_SHIFT:   page_shift_q   <= pwdata[4:0];
        REG_START_OFFSET: start_offset_q <= pwdata[47:0];
        REG_READ_LENGTH:  read_length_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAGE_SHIFT:   prdata = APB_DATA_W'(page_shift_q);
      REG_START_OFFSET: prdata = APB_DATA_W'(start_offset_q);
      REG_READ_LENGTH:  prdata = APB_DATA_W'(read_length_q);
      default:          prdata = '0;
    endcase
  end

  // intake and classification
  pcsr_front #(
    .MAX_PAGE_SHIFT (MAX_PAGE_SHIFT),
    .OFFSET_WIDTH   (OFFSET_WIDTH)
  ) u_front (
    .in_item_i      (in_item_i),
    .page_shift_i   (page_shift_q),
    .start_offset_i (start_offset_q),
    .read_length_i  (read_length_q),
    .cmd_o          (f_cmd),
    .in_page_o      (f_in_page),
    .offset_o       (f_offset)
  );

  assign in_ready_o = !q_full;

  // decoupling queue, carries the register snapshot with each byte
  pcsr_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i ({f_cmd, f_in_page, f_offset}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign {h_cmd, h_in_page, h_offset} = q_rdata;

  // page walker and output register
  pcsr_back #(
    .MAX_PAGE_SHIFT (MAX_PAGE_SHIFT),
    .OFFSET_WIDTH   (OFFSET_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .cmd_i        (h_cmd),
    .in_page_i    (h_in_page),
    .offset_i     (h_offset),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== rtl/pcsr_checker.sv =====
// ----------------------------------------------------------------------------
// pcsr_checker
// port-level checks on the result stream of the stream reader
// ----------------------------------------------------------------------------
module pcsr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pcsr_pkg::out_item_t out_item_o,
  input logic                pready
);
  import pcsr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // errors always close the transfer
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_CRC_ERR || out_item_o.kind == KIND_OFS_ERR)
    |-> out_item_o.last)
    else $error("error item without last");

  // data only on payload items
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_DATA |-> out_item_o.data == 8'd0)
    else $error("data set on status item");

  // resume offset only on the final ok item
  a_next_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_item_o.last && out_item_o.kind == KIND_PAGE_OK)
    |-> out_item_o.next_offset == 48'd0)
    else $error("resume offset on wrong item");

  // payload items carry no crc and never close the transfer
  a_data_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_DATA
    |-> !out_item_o.last && out_item_o.page_crc == 32'd0 && pready)
    else $error("malformed payload item");

endmodule

bind paged_crc32c_stream_reader_unit pcsr_checker u_pcsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the paged crc32c stream reader: builds whole pages
// with valid or damaged checksums, streams them under random flow control on
// both channels, predicts every payload byte and page status item, and
// compares results field by field as they leave the block
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcsr_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 4;
  localparam int          MAX_SHIFT    = 16;
  localparam int          TOTAL_ITEMS  = 550;
  localparam int          DRAIN_CYCLES = 8;       // drain margin for the fifo and the output register
  localparam int          MAX_SHOWN    = 10;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam logic [31:0] CASTAGNOLI   = 32'h82f6_3b78;
  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // block ports
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item  = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_item_t             out_item_o;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  paged_crc32c_stream_reader_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // raw bytes waiting to be offered, and predicted reader output
  in_item_t  byte_q[$];
  out_item_t pending_results[$];

  int  errors     = 0;
  int  sent_items = 0;
  int  cycles     = 0;
  bit  no_idle    = 1'b0;   // set for stretches with back-to-back transfers
  int  gap_left   = 0;
  int  stall_left = 0;

  // register copies, written when the apb write lands
  logic [4:0]  cfg_shift = PAGE_SHIFT_RST;
  logic [47:0] cfg_start = '0;
  logic [31:0] cfg_len   = '0;

  // page walker copy
  logic [31:0] crc_run   = ALL_ONES;
  logic [31:0] pg_pos    = '0;
  logic [31:0] chk_word  = '0;
  logic [31:0] left_cnt  = '0;
  logic [47:0] pg_no     = '0;
  bit          rd_busy   = 1'b0;
  bit          rd_first  = 1'b0;
  bit          rd_ending = 1'b0;
  logic [47:0] rd_resume = '0;

  // reflected crc-32c, one byte, shift-and-mask form
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    repeat (8) x = (x >> 1) ^ (CASTAGNOLI & {32{x[0]}});
    return x;
  endfunction

  // page size is clamped to 8 bytes .. 2^MAX_SHIFT bytes
  function automatic int unsigned eff_shift(logic [4:0] s);
    if (s < 5'd3) return 3;
    if (s > 5'(MAX_SHIFT)) return MAX_SHIFT;
    return {27'd0, s};
  endfunction

  function automatic int unsigned page_size();
    return 32'd1 << eff_shift(cfg_shift);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch %0d: %s", errors, msg);
  endfunction

  // advance the walker copy by one accepted byte and queue what it emits
  function automatic void walk_byte(in_item_t it);
    int unsigned sh;
    logic [31:0] size, payload, in_page, p, crc;
    logic [63:0] end_at;
    out_item_t   res;
    sh      = eff_shift(cfg_shift);
    size    = 32'd1 << sh;
    payload = size - 32'd4;
    in_page = cfg_start[31:0] & (size - 32'd1);
    res     = '0;
    if (it.start_req) begin
      rd_busy = 1'b0;
      // start inside the checksum area
      if (in_page >= payload) begin
        res.kind = KIND_OFS_ERR;
        res.last = 1'b1;
        pending_results.push_back(res);
        return;
      end
      // nothing to read: done on the start byte itself
      if (cfg_len == 32'd0) begin
        res.kind        = KIND_PAGE_OK;
        res.last        = 1'b1;
        res.next_offset = cfg_start;
        pending_results.push_back(res);
        return;
      end
      rd_busy   = 1'b1;
      rd_first  = 1'b1;
      rd_ending = 1'b0;
      crc_run   = ALL_ONES;
      pg_pos    = '0;
      chk_word  = '0;
      left_cnt  = cfg_len;
      pg_no     = cfg_start >> sh;
      rd_resume = '0;
    end
    if (!rd_busy) return;
    p = pg_pos;
    if (p < payload) begin
      crc_run = crc_step(crc_run, it.page_byte);
      pg_pos  = p + 32'd1;
      if (left_cnt != 32'd0 && (!rd_first || p >= in_page)) begin
        left_cnt--;
        if (left_cnt == 32'd0) begin
          end_at = ({16'd0, pg_no} << sh) + {32'd0, p} + 64'd1;
          // a read ending on the payload end resumes past the checksum
          if (p + 32'd1 == payload) end_at = end_at + 64'd4;
          rd_resume = end_at[47:0];
          rd_ending = 1'b1;
        end
        res.kind = KIND_DATA;
        res.data = it.page_byte;
        pending_results.push_back(res);
      end
      return;
    end
    // checksum bytes, most significant first; a position past the page end
    // after a shift change counts as the last byte
    chk_word = {chk_word[23:0], it.page_byte};
    if (p < size - 32'd1) begin
      pg_pos = p + 32'd1;
      return;
    end
    crc           = crc_run ^ ALL_ONES;
    res.page_crc  = crc;
    if (crc != chk_word) begin
      rd_busy  = 1'b0;
      res.kind = KIND_CRC_ERR;
      res.last = 1'b1;
    end else if (rd_ending) begin
      rd_busy         = 1'b0;
      res.kind        = KIND_PAGE_OK;
      res.last        = 1'b1;
      res.next_offset = rd_resume;
    end else begin
      pg_no    = pg_no + 48'd1;
      pg_pos   = '0;
      crc_run  = ALL_ONES;
      chk_word = '0;
      rd_first = 1'b0;
      res.kind = KIND_PAGE_OK;
    end
    pending_results.push_back(res);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t w;
    if (pending_results.size() == 0) begin
      note_error($sformatf("unexpected result kind %0d data %02h last %0b",
                           got.kind, got.data, got.last));
      return;
    end
    w = pending_results.pop_front();
    if (got.kind !== w.kind)
      note_error($sformatf("kind: expected %0d, got %0d", w.kind, got.kind));
    if (got.data !== w.data)
      note_error($sformatf("data: expected %02h, got %02h", w.data, got.data));
    if (got.last !== w.last)
      note_error($sformatf("last: expected %0b, got %0b", w.last, got.last));
    if (got.next_offset !== w.next_offset)
      note_error($sformatf("next_offset: expected %012h, got %012h",
                           w.next_offset, got.next_offset));
    if (got.page_crc !== w.page_crc)
      note_error($sformatf("page_crc: expected %08h, got %08h", w.page_crc, got.page_crc));
  endfunction

  // input driver: offer queued bytes, random gaps after a transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        walk_byte(in_item);
        sent_items++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_item  <= byte_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= (!no_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: check each transfer, stall the receiver at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready) check_result(out_item_o);
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 99) < 20) begin
        out_ready  <= 1'b0;
        stall_left <= idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // apb write: setup phase, then access phase, at whose end the register lands
  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PAGE_SHIFT:   cfg_shift = val[4:0];
      REG_START_OFFSET: cfg_start = val[47:0];
      REG_READ_LENGTH:  cfg_len   = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [4:0] sh, logic [47:0] so, logic [31:0] len);
    reg_write(REG_PAGE_SHIFT, {59'd0, sh});
    reg_write(REG_START_OFFSET, {16'd0, so});
    reg_write(REG_READ_LENGTH, {32'd0, len});
  endtask

  // wait until every byte is taken and every result is back, then let
  // bytes that give no result drain out of the pipeline
  task automatic settle();
    @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic void push_byte(bit start);
    in_item_t it;
    it.page_byte = 8'($urandom);
    it.start_req = start;
    byte_q.push_back(it);
  endfunction

  // whole pages from the page holding start_offset, start flag on byte 0;
  // optional damaged byte and early cut for restarts
  function automatic void queue_transfer(int unsigned n_pages, int bad_at, int keep, int fill);
    in_item_t    q[$];
    in_item_t    it;
    logic [31:0] c;
    int unsigned sz;
    sz = page_size();
    for (int unsigned pg = 0; pg < n_pages; pg++) begin
      c = ALL_ONES;
      for (int unsigned i = 0; i < sz - 4; i++) begin
        it.page_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
        it.start_req = (pg == 0 && i == 0);
        c = crc_step(c, it.page_byte);
        q.push_back(it);
      end
      c = ~c;
      for (int k = 3; k >= 0; k--) begin
        it.page_byte = c[8*k +: 8];
        it.start_req = 1'b0;
        q.push_back(it);
      end
    end
    if (bad_at >= 0 && bad_at < q.size()) begin
      it = q[bad_at];
      it.page_byte = it.page_byte ^ 8'($urandom_range(1, 255));
      q[bad_at] = it;
    end
    if (keep < 0 || keep > q.size()) keep = q.size();
    for (int i = 0; i < keep; i++) byte_q.push_back(q[i]);
  endfunction

  function automatic int unsigned pages_needed(int unsigned cap);
    longint unsigned sz, pl, ip, n;
    sz = page_size();
    pl = sz - 4;
    ip = cfg_start & (sz - 1);
    n  = (ip + cfg_len + pl - 1) / pl;
    return (n > cap) ? cap : int'(n);
  endfunction

  // random upper bits with a chosen in-page offset
  function automatic logic [47:0] rand_offset(int unsigned sz, int unsigned ip);
    logic [63:0] t;
    logic [47:0] m;
    t = {$urandom(), $urandom()};
    m = 48'(sz) - 48'd1;
    return (t[47:0] & ~m) | 48'(ip);
  endfunction

  task automatic random_phase();
    int unsigned r, sz, pl, ip, np;
    logic [4:0]  sh;
    logic [31:0] len;
    bit          cheap;
    int          bad_at, keep;
    cheap = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 60) sh = 5'($urandom_range(3, 4));
    else if (r < 75) sh = 5'($urandom_range(0, 2));
    else if (r < 88) sh = 5'd5;
    else if (r < 95) sh = 5'($urandom_range(6, 7));
    else begin
      // large pages: only starts that finish at once
      sh    = 5'($urandom_range(8, 31));
      cheap = 1'b1;
    end
    sz = 32'd1 << eff_shift(sh);
    pl = sz - 4;
    r  = $urandom_range(0, 99);
    if (r < 12 || (cheap && r < 50)) ip = $urandom_range(pl, sz - 1);
    else ip = $urandom_range(0, pl - 1);
    r = $urandom_range(0, 99);
    if (r < 10 || cheap) len = '0;
    else if (r < 18) len = $urandom();
    else len = $urandom_range(1, 3 * pl);
    set_regs(sh, rand_offset(sz, ip), len);
    @(negedge clk_i);
    no_idle = ($urandom_range(0, 9) == 0);
    // stray bytes; ignored while idle, consumed if a long read is still open
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) push_byte(1'b0);
    if (ip >= pl || len == 0) begin
      push_byte(1'b1);
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) push_byte(1'b0);
    end else begin
      np     = pages_needed((sz > 32) ? 2 : 4);
      bad_at = ($urandom_range(0, 99) < 12) ? int'($urandom_range(0, np * sz - 1)) : -1;
      // abandoned transfer, restarted from the top
      if ($urandom_range(0, 99) < 8) begin
        keep = $urandom_range(1, np * sz - 1);
        queue_transfer(np, -1, keep, -1);
      end
      queue_transfer(np, bad_at, -1, -1);
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: stray bytes ignored, then a zero-length read at offset 0
    push_byte(1'b0);
    push_byte(1'b0);
    push_byte(1'b1);
    settle();

    // smallest page, read ends on the payload end, all-ones content
    set_regs(5'd3, 48'd0, 32'd4);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), -1, -1, 8'hff);
    settle();

    // two pages of zeros, intermediate page status
    set_regs(5'd3, 48'd8, 32'd8);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), -1, -1, 0);
    settle();

    // shift below the minimum, read across three pages
    set_regs(5'd0, rand_offset(8, 1), 32'd9);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), -1, -1, -1);
    settle();

    // start inside the checksum area, following bytes ignored
    set_regs(5'd4, rand_offset(16, 12), 32'd5);
    @(negedge clk_i);
    push_byte(1'b1);
    repeat (3) push_byte(1'b0);
    settle();

    // damaged payload byte, rest of the stream ignored
    set_regs(5'd5, rand_offset(32, 3), 32'd40);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), 10, -1, -1);
    settle();

    // damaged checksum byte
    set_regs(5'd5, rand_offset(32, 0), 32'd20);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), 29, -1, -1);
    settle();

    // restart in the middle of a transfer
    set_regs(5'd4, rand_offset(16, 2), 32'd30);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), -1, 20, -1);
    queue_transfer(pages_needed(8), -1, -1, -1);
    settle();

    // top of the offset space, resume offset wraps to zero
    set_regs(5'd3, 48'hffff_ffff_fff8, 32'd4);
    @(negedge clk_i);
    queue_transfer(pages_needed(8), -1, -1, -1);
    settle();

    // largest start offset
    set_regs(5'd6, 48'hffff_ffff_ffff, 32'd10);
    @(negedge clk_i);
    push_byte(1'b1);
    settle();

    // longest read, left open
    set_regs(5'd3, rand_offset(8, 0), 32'hffff_ffff);
    @(negedge clk_i);
    queue_transfer(3, -1, -1, -1);
    settle();

    // page shift shrinks under an open transfer
    set_regs(5'd6, 48'd0, 32'd100);
    @(negedge clk_i);
    queue_transfer(1, -1, 40, -1);
    settle();
    reg_write(REG_PAGE_SHIFT, {59'd0, 5'd3});
    @(negedge clk_i);
    repeat (6) push_byte(1'b0);
    settle();

    // 64-byte page back to back, read ends on the payload end
    set_regs(5'd6, rand_offset(64, 57), 32'd3);
    @(negedge clk_i);
    no_idle = 1'b1;
    queue_transfer(pages_needed(1), -1, -1, -1);
    settle();
    no_idle = 1'b0;

    // shift above the maximum: offset error, then zero length
    set_regs(5'd31, rand_offset(65536, 65532), 32'd7);
    @(negedge clk_i);
    push_byte(1'b1);
    settle();
    set_regs(5'd31, rand_offset(65536, 5), 32'd0);
    @(negedge clk_i);
    push_byte(1'b1);
    settle();

    // random phases
    while (sent_items < TOTAL_ITEMS) random_phase();
    settle();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
